### hw/rtl/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// shared types, register codes and helpers of the two-way lru cache lookup
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int ADDR_FIELD_W = 32;
    localparam int CFG_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int SET_OUT_W    = 8;
    localparam int CNT_W        = 32;
    // widest set number that a 4-bit set count register can select
    localparam int RAW_IDX_W    = (1 << CFG_W) - 1;

    localparam logic [CFG_W-1:0] BLOCK_SIZE_LOG2_RST = 4'd4;
    localparam logic [CFG_W-1:0] SET_COUNT_LOG2_RST  = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BLOCK_SIZE_LOG2 = 1'b0,
        REG_SET_COUNT_LOG2  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic                    hit;
        logic [SET_OUT_W-1:0]    set_index;
        logic [ADDR_FIELD_W-1:0] block_address;
        logic                    filled_way;
        logic [CNT_W-1:0]        access_count;
        logic [CNT_W-1:0]        miss_count;
    } t_result;

    typedef struct packed {
        logic req_pop;
        logic res_push;
        logic clearing;
    } t_back_ctl;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

endpackage

### hw/rtl/tlc_fifo.sv
// ----------------------------------------------------------------------------
// tlc_fifo
// small first-in first-out buffer with occupancy count
// ----------------------------------------------------------------------------
module tlc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic [WIDTH-1:0]               i_data,
    input  logic                           i_pop,
    output logic [WIDTH-1:0]               o_data,
    output logic                           o_empty,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign w_push_ok = i_push && (r_count != CNT_W'(DEPTH));
    assign w_pop_ok  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push_ok && !w_pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop_ok && !w_push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

### hw/rtl/tlc_front.sv
// ----------------------------------------------------------------------------
// tlc_front
// config registers, block address and set number of each accepted address
// ----------------------------------------------------------------------------
module tlc_front import tlc_pkg::*; #(
    parameter int SETS   = 256,
    parameter int ADDR_W = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_addr,
    input  logic [CFG_W-1:0]                      i_cfg_wr_data,
    input  logic                                  i_valid,
    input  logic [ADDR_FIELD_W-1:0]               i_address,
    output logic                                  o_valid,
    output logic [ADDR_FIELD_W-1:0]               o_blk_addr,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] o_set_idx,
    output logic [1:0]                            o_busy
);

    localparam int AW    = (ADDR_W < ADDR_FIELD_W) ? ADDR_W : ADDR_FIELD_W;
    localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int LOG_D = $clog2(SETS);
    // reciprocal of SETS, exact for every raw set number
    localparam int K     = RAW_IDX_W + LOG_D;
    localparam int M_W   = K + 1;
    localparam longint unsigned M_FULL =
        ((64'd1 << K) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [M_W-1:0] M_C = M_W'(M_FULL);
    localparam int D_W = 17;
    localparam logic [D_W-1:0] SETS_C = D_W'(SETS);
    localparam logic [ADDR_FIELD_W-1:0] AMASK = 32'hFFFF_FFFF >> (ADDR_FIELD_W - AW);

    logic [CFG_W-1:0]               r_block_size_log2;
    logic [CFG_W-1:0]               r_set_count_log2;

    logic [ADDR_FIELD_W-1:0]        w_addr;
    logic [ADDR_FIELD_W-1:0]        w_blk_num;
    logic [RAW_IDX_W-1:0]           w_raw_mask;

    logic                           r_a_valid;
    logic [ADDR_FIELD_W-1:0]        r_a_blk;
    logic [RAW_IDX_W-1:0]           r_a_raw;
    logic [RAW_IDX_W+M_W-1:0]       w_prod_a;

    logic                           r_b_valid;
    logic [ADDR_FIELD_W-1:0]        r_b_blk;
    logic [RAW_IDX_W-1:0]           r_b_raw;
    logic [RAW_IDX_W-1:0]           r_b_quo;
    logic [RAW_IDX_W+D_W-1:0]       w_prod_b;
    logic [RAW_IDX_W+D_W-1:0]       w_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size_log2 <= BLOCK_SIZE_LOG2_RST;
            r_set_count_log2  <= SET_COUNT_LOG2_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_BLOCK_SIZE_LOG2: r_block_size_log2 <= i_cfg_wr_data;
                REG_SET_COUNT_LOG2:  r_set_count_log2  <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // block number, block address and set number before the modulo
    always_comb begin
        w_addr     = i_address & AMASK;
        w_blk_num  = w_addr >> r_block_size_log2;
        w_raw_mask = (RAW_IDX_W'(1) << r_set_count_log2) - RAW_IDX_W'(1);
    end

    assign w_prod_a = {{M_W{1'b0}}, r_a_raw} * {{RAW_IDX_W{1'b0}}, M_C};
    assign w_prod_b = {{D_W{1'b0}}, r_b_quo} * {{RAW_IDX_W{1'b0}}, SETS_C};
    assign w_rem    = {{D_W{1'b0}}, r_b_raw} - w_prod_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_blk <= w_blk_num << r_block_size_log2;
        r_a_raw <= w_blk_num[RAW_IDX_W-1:0] & w_raw_mask;
        r_b_blk <= r_a_blk;
        r_b_raw <= r_a_raw;
        r_b_quo <= w_prod_a[K +: RAW_IDX_W];
    end

    assign o_valid    = r_b_valid;
    assign o_blk_addr = r_b_blk;
    assign o_set_idx  = w_rem[SW-1:0];
    assign o_busy     = {1'b0, r_a_valid} + {1'b0, r_b_valid};

endmodule

### hw/rtl/tlc_back.sv
// ----------------------------------------------------------------------------
// tlc_back
// set memory, tag compare, lru update and saturating counters
// ----------------------------------------------------------------------------
module tlc_back import tlc_pkg::*; #(
    parameter int SETS   = 256,
    parameter int ADDR_W = 32
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_req_valid,
    input  logic [ADDR_FIELD_W-1:0]                    i_req_blk,
    input  logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] i_req_set,
    input  logic                                       i_res_space,
    output t_back_ctl                                  o_ctl,
    output t_result                                    o_result
);

    localparam int AW       = (ADDR_W < ADDR_FIELD_W) ? ADDR_W : ADDR_FIELD_W;
    localparam int SW       = (SETS > 1) ? $clog2(SETS) : 1;
    // row layout: lru, valid 1, tag 1, valid 0, tag 0
    localparam int TAG0_LSB = 0;
    localparam int V0_BIT   = AW;
    localparam int TAG1_LSB = AW + 1;
    localparam int V1_BIT   = 2 * AW + 1;
    localparam int LRU_BIT  = 2 * AW + 2;
    localparam int ROW_W    = 2 * AW + 3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } t_state;

    t_state                  r_state;
    logic [SW-1:0]           r_clr_ptr;
    logic [CNT_W-1:0]        r_acc;
    logic [CNT_W-1:0]        r_miss;
    logic [ADDR_FIELD_W-1:0] r_blk;
    logic [SW-1:0]           r_set;

    logic [ROW_W-1:0]        r_mem [SETS];
    logic [ROW_W-1:0]        r_rd_row;
    logic [ROW_W-1:0]        n_row;

    logic                    w_start;
    logic                    w_hit0;
    logic                    w_hit1;
    logic                    w_hit;
    logic                    w_way;
    logic                    w_wr_en;
    logic [SW-1:0]           w_wr_addr;
    logic [ROW_W-1:0]        w_wr_row;
    logic [CNT_W-1:0]        n_acc;
    logic [CNT_W-1:0]        n_miss;

    assign w_start = (r_state == S_IDLE) && i_req_valid && i_res_space;

    always_comb begin
        w_hit0 = r_rd_row[V0_BIT] && (r_rd_row[TAG0_LSB +: AW] == r_blk[AW-1:0]);
        w_hit1 = r_rd_row[V1_BIT] && (r_rd_row[TAG1_LSB +: AW] == r_blk[AW-1:0]);
        w_hit  = w_hit0 || w_hit1;
        w_way  = w_hit0 ? 1'b0 : (w_hit1 ? 1'b1 : r_rd_row[LRU_BIT]);

        n_row          = r_rd_row;
        n_row[LRU_BIT] = ~w_way;
        if (!w_hit) begin
            if (w_way) begin
                n_row[TAG1_LSB +: AW] = r_blk[AW-1:0];
                n_row[V1_BIT]         = 1'b1;
            end else begin
                n_row[TAG0_LSB +: AW] = r_blk[AW-1:0];
                n_row[V0_BIT]         = 1'b1;
            end
        end

        w_wr_en   = (r_state == S_CLEAR) || (r_state == S_LOOK);
        w_wr_addr = (r_state == S_CLEAR) ? r_clr_ptr : r_set;
        w_wr_row  = (r_state == S_CLEAR) ? '0 : n_row;

        n_acc  = sat_inc(r_acc);
        n_miss = w_hit ? r_miss : sat_inc(r_miss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_ptr <= '0;
            r_acc     <= '0;
            r_miss    <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + 1'b1;
                    if (r_clr_ptr == SW'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_acc   <= n_acc;
                    r_miss  <= n_miss;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_blk <= i_req_blk;
            r_set <= i_req_set;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_row;
        end
        r_rd_row <= r_mem[i_req_set];
    end

    always_comb begin
        o_ctl.req_pop  = w_start;
        o_ctl.res_push = (r_state == S_LOOK);
        o_ctl.clearing = (r_state == S_CLEAR);

        o_result.hit           = w_hit;
        o_result.set_index     = SET_OUT_W'(r_set);
        o_result.block_address = r_blk;
        o_result.filled_way    = w_way;
        o_result.access_count  = n_acc;
        o_result.miss_count    = n_miss;
    end

endmodule

### hw/rtl/two_way_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// two_way_lru_cache_lookup
// two-way set-associative cache model with lru replacement and hit/miss counts
// ----------------------------------------------------------------------------
//  channel   handshake          word
//  --------  -----------------  ---------------------------------------------
//  request   push / full        i_address
//  result    pop / empty        o_hit o_set_index o_block_address
//                               o_filled_way o_access_count o_miss_count
//  config    i_cfg_wr_en        i_cfg_addr i_cfg_wr_data (no read-back)
//
//  a word passes the front stages in turn (shift and mask, then the
//  reciprocal multiply that folds the set number into SETS)
//  the back takes one word at a time: a set memory read, then compare and
//  write-back of the row; it takes no new word before that one is done
//  after reset a clearing pass writes every set row, with full high
//  full also rises when the middle queue and the front stages are all taken;
//  the back stops when the result queue has no room
// ----------------------------------------------------------------------------
module two_way_lru_cache_lookup import tlc_pkg::*; #(
    parameter int SETS   = 256,
    parameter int ADDR_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [CFG_W-1:0]        i_cfg_wr_data,
    // request side
    input  logic                    push,
    output logic                    full,
    input  logic [ADDR_FIELD_W-1:0] i_address,
    // result side
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_hit,
    output logic [SET_OUT_W-1:0]    o_set_index,
    output logic [ADDR_FIELD_W-1:0] o_block_address,
    output logic                    o_filled_way,
    output logic [CNT_W-1:0]        o_access_count,
    output logic [CNT_W-1:0]        o_miss_count
);

    localparam int SW        = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MID_DEPTH = 4;
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int MID_W     = ADDR_FIELD_W + SW;
    localparam int OUT_DEPTH = 2;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);
    localparam int CREDIT_W  = MID_CW + 1;

    logic                    w_accept;
    logic                    w_f_valid;
    logic [ADDR_FIELD_W-1:0] w_f_blk;
    logic [SW-1:0]           w_f_set;
    logic [1:0]              w_f_busy;

    logic [MID_W-1:0]        w_mid_data;
    logic                    w_mid_empty;
    logic [MID_CW-1:0]       w_mid_count;

    t_back_ctl               w_ctl;
    t_result                 w_res;
    logic [$bits(t_result)-1:0] w_out_data;
    logic [OUT_CW-1:0]       w_out_count;
    t_result                 w_out;

    // words in the front stages already hold a place in the middle queue
    assign full = w_ctl.clearing ||
                  ((CREDIT_W'(w_mid_count) + CREDIT_W'(w_f_busy)) >= CREDIT_W'(MID_DEPTH));
    assign w_accept = push && !full;

    tlc_front #(
        .SETS   (SETS),
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (w_accept),
        .i_address     (i_address),
        .o_valid       (w_f_valid),
        .o_blk_addr    (w_f_blk),
        .o_set_idx     (w_f_set),
        .o_busy        (w_f_busy)
    );

    // decoupling queue between classification and lookup
    tlc_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  ({w_f_blk, w_f_set}),
        .i_pop   (w_ctl.req_pop),
        .o_data  (w_mid_data),
        .o_empty (w_mid_empty),
        .o_count (w_mid_count)
    );

    tlc_back #(
        .SETS   (SETS),
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (!w_mid_empty),
        .i_req_blk   (w_mid_data[SW +: ADDR_FIELD_W]),
        .i_req_set   (w_mid_data[SW-1:0]),
        .i_res_space (w_out_count != OUT_CW'(OUT_DEPTH)),
        .o_ctl       (w_ctl),
        .o_result    (w_res)
    );

    // result queue, the skid between the back and the consumer
    tlc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl.res_push),
        .i_data  (w_res),
        .i_pop   (pop),
        .o_data  (w_out_data),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign w_out           = t_result'(w_out_data);
    assign o_hit           = w_out.hit;
    assign o_set_index     = w_out.set_index;
    assign o_block_address = w_out.block_address;
    assign o_filled_way    = w_out.filled_way;
    assign o_access_count  = w_out.access_count;
    assign o_miss_count    = w_out.miss_count;

endmodule

### hw/rtl/tlc_checker.sv
// ----------------------------------------------------------------------------
// tlc_checker
// port-level checks of the two-way lru cache lookup
// ----------------------------------------------------------------------------
module tlc_checker import tlc_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    full,
    input logic                    empty,
    input logic                    pop,
    input logic                    o_hit,
    input logic [CNT_W-1:0]        o_access_count,
    input logic [CNT_W-1:0]        o_miss_count
);

    // clearing pass holds off requests and nothing waits on the result side
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> full && empty)
        else $error("full or empty wrong after reset");

    a_miss_le_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_miss_count <= o_access_count)
        else $error("miss count above access count");

    a_miss_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_hit |-> o_miss_count != '0)
        else $error("miss shown with zero miss count");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_access_count))
        else $error("waiting word changed");

endmodule

bind two_way_lru_cache_lookup tlc_checker u_tlc_checker (.*);

### sim/tb_two_way_lru_cache_lookup.sv
// ----------------------------------------------------------------------------
// tb_two_way_lru_cache_lookup
// self-checking bench: a cycle-free model of the two-way lru cache predicts
// every result word, directed and random address traffic runs under several
// register settings and idle patterns, and one long result hold-off fills it
// ----------------------------------------------------------------------------
module tb_two_way_lru_cache_lookup;
    timeunit 1ns;
    timeprecision 1ps;

    import tlc_pkg::*;

    localparam int SETS_N   = 256;
    localparam int POOL_N   = 16;
    localparam int MAX_SHOW = 30;

    // dut ports
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_addr;
    logic [CFG_W-1:0]        i_cfg_wr_data;
    logic                    push;
    logic                    full;
    logic [ADDR_FIELD_W-1:0] i_address;
    logic                    empty;
    logic                    pop;
    logic                    o_hit;
    logic [SET_OUT_W-1:0]    o_set_index;
    logic [ADDR_FIELD_W-1:0] o_block_address;
    logic                    o_filled_way;
    logic [CNT_W-1:0]        o_access_count;
    logic [CNT_W-1:0]        o_miss_count;

    // cache model state, kept in step with every accepted word
    logic [ADDR_FIELD_W-1:0] tag_mem   [2*SETS_N];
    logic                    valid_mem [2*SETS_N];
    logic                    lru_mem   [SETS_N];
    logic [CNT_W-1:0]        access_tally;
    logic [CNT_W-1:0]        miss_tally;
    logic [CFG_W-1:0]        cfg_block_log2;
    logic [CFG_W-1:0]        cfg_set_log2;

    // lookups predicted but not yet popped, oldest first
    t_result                 pending_lookups[$];

    // idle pattern of both sides, in percent per cycle
    int unsigned             send_idle_pct;
    int unsigned             recv_stall_pct;
    int unsigned             hold_request;
    int unsigned             mismatch_count;
    bit                      out_of_reset;

    // hot block addresses so the random traffic hits and evicts
    logic [ADDR_FIELD_W-1:0] hot_pool[POOL_N];

    two_way_lru_cache_lookup #(
        .SETS   (SETS_N),
        .ADDR_W (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .push            (push),
        .full            (full),
        .i_address       (i_address),
        .empty           (empty),
        .pop             (pop),
        .o_hit           (o_hit),
        .o_set_index     (o_set_index),
        .o_block_address (o_block_address),
        .o_filled_way    (o_filled_way),
        .o_access_count  (o_access_count),
        .o_miss_count    (o_miss_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // cache model
    // ------------------------------------------------------------------------

    task automatic clear_model();
        for (int i = 0; i < 2*SETS_N; i++) begin
            tag_mem[i]   = '0;
            valid_mem[i] = 1'b0;
        end
        for (int i = 0; i < SETS_N; i++) lru_mem[i] = 1'b0;
        access_tally   = '0;
        miss_tally     = '0;
        cfg_block_log2 = BLOCK_SIZE_LOG2_RST;
        cfg_set_log2   = SET_COUNT_LOG2_RST;
    endtask

    // one lookup: works out the result word and updates tags, valid and lru
    function automatic t_result predict_lookup(input logic [ADDR_FIELD_W-1:0] addr);
        t_result                 res;
        logic [ADDR_FIELD_W-1:0] blk_num;
        logic [ADDR_FIELD_W-1:0] blk_addr;
        logic [ADDR_FIELD_W-1:0] set_mask;
        int unsigned             set_no;
        int unsigned             base;
        logic                    way;
        logic                    found;
        blk_num  = addr >> cfg_block_log2;
        blk_addr = blk_num << cfg_block_log2;
        set_mask = (32'd1 << cfg_set_log2) - 32'd1;
        // sets in use beyond SETS fold back modulo SETS
        set_no   = (blk_num & set_mask) % SETS_N;
        base     = set_no * 2;

        if (access_tally != '1) access_tally = access_tally + 1'b1;

        // way 0 is looked at first, invalid ways never match
        if (valid_mem[base] && tag_mem[base] == blk_addr) begin
            found = 1'b1;
            way   = 1'b0;
        end else if (valid_mem[base+1] && tag_mem[base+1] == blk_addr) begin
            found = 1'b1;
            way   = 1'b1;
        end else begin
            found = 1'b0;
            way   = lru_mem[set_no];
            tag_mem[base + way]   = blk_addr;
            valid_mem[base + way] = 1'b1;
            if (miss_tally != '1) miss_tally = miss_tally + 1'b1;
        end
        lru_mem[set_no] = ~way;

        res.hit           = found;
        res.set_index     = set_no[SET_OUT_W-1:0];
        res.block_address = blk_addr;
        res.filled_way    = way;
        res.access_count  = access_tally;
        res.miss_count    = miss_tally;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // reporting and result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOW)
            $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, got_v);
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) report_mismatch(what, exp_v, got_v);
    endtask

    task automatic check_lookup(input t_result got);
        t_result want;
        if (pending_lookups.size() == 0) begin
            report_mismatch("unexpected result word, block address", '0, got.block_address);
        end else begin
            want = pending_lookups.pop_front();
            check_field("hit",           want.hit,           got.hit);
            check_field("set_index",     want.set_index,     got.set_index);
            check_field("block_address", want.block_address, got.block_address);
            check_field("filled_way",    want.filled_way,    got.filled_way);
            check_field("access_count",  want.access_count,  got.access_count);
            check_field("miss_count",    want.miss_count,    got.miss_count);
        end
    endtask

    // result side: outputs are sampled mid-cycle, pop is changed at the edge
    initial begin
        t_result     seen;
        bit          taking;
        int unsigned hold_left;
        hold_left = 0;
        wait (out_of_reset);
        forever begin
            @(negedge i_clk);
            taking = pop && !empty;
            seen.hit           = o_hit;
            seen.set_index     = o_set_index;
            seen.block_address = o_block_address;
            seen.filled_way    = o_filled_way;
            seen.access_count  = o_access_count;
            seen.miss_count    = o_miss_count;
            @(posedge i_clk);
            if (taking) check_lookup(seen);
            // a requested hold-off is counted down here, cycle by cycle
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // request side and register writes, all entered and left at a rising edge
    // ------------------------------------------------------------------------

    task automatic send_address(input logic [ADDR_FIELD_W-1:0] addr);
        bit room;
        // random gap in front of the word
        if ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        push      <= 1'b1;
        i_address <= addr;
        do begin
            @(negedge i_clk);
            room = !full;
            @(posedge i_clk);
        end while (!room);
        pending_lookups.push_back(predict_lookup(addr));
    endtask

    // wait until every word is back, then give the pipeline time to settle
    task automatic drain();
        push <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx which, input logic [CFG_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= which;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        case (which)
            REG_BLOCK_SIZE_LOG2: cfg_block_log2 = value;
            REG_SET_COUNT_LOG2:  cfg_set_log2   = value;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] blk_log2,
                                input logic [CFG_W-1:0] set_log2);
        write_register(REG_BLOCK_SIZE_LOG2, blk_log2);
        write_register(REG_SET_COUNT_LOG2, set_log2);
    endtask

    // ------------------------------------------------------------------------
    // address generation for the random traffic
    // ------------------------------------------------------------------------

    task automatic refill_pool();
        for (int i = 0; i < POOL_N; i++) begin
            hot_pool[i] = $urandom;
            // each entry after the first may, at random, share its low half with the
            // previous one, so small geometries put them in the same set and force evictions
            if (i > 0 && $urandom_range(1) == 1)
                hot_pool[i][15:0] = hot_pool[i-1][15:0];
        end
    endtask

    function automatic logic [ADDR_FIELD_W-1:0] pick_address();
        int unsigned             r;
        logic [ADDR_FIELD_W-1:0] offset_mask;
        r           = $urandom_range(99);
        offset_mask = (32'd1 << cfg_block_log2) - 32'd1;
        if (r < 65)
            return hot_pool[$urandom_range(POOL_N-1)] ^ ($urandom & offset_mask);
        else if (r < 85)
            return $urandom;
        else if (r < 93)
            return $urandom_range(255);
        else
            return 32'hFFFF_FFFF - $urandom_range(255);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset geometry: cold misses, hits in both ways, conflict eviction, edges
    task automatic test_reset_geometry();
        send_address(32'h0000_0000);    // cold miss fills way 0
        send_address(32'h0000_0000);    // hit in way 0
        send_address(32'h0000_000F);    // same block, last offset
        send_address(32'h0000_1000);    // same set, fills way 1
        send_address(32'h0000_1004);    // hit in way 1
        send_address(32'h0000_2000);    // set full, evicts the lru way
        send_address(32'h0000_0000);    // evicted by the previous word, misses again
        send_address(32'h0000_1000);
        send_address(32'hFFFF_FFFF);    // top set, all ones
        send_address(32'hFFFF_FFF0);    // hit on the all-ones block
        send_address(32'hAAAA_AAAA);
        send_address(32'h5555_5555);
        send_address(32'hAAAA_AAA0);
    endtask

    // register extremes: one set, shift above twelve, sets beyond SETS
    task automatic test_register_extremes();
        set_geometry(4'd0, 4'd0);       // byte blocks, single set
        send_address(32'h0000_0001);
        send_address(32'h0000_0002);
        send_address(32'h0000_0001);
        set_geometry(4'd15, 4'd15);     // widest shift, set number folded into SETS
        send_address(32'hFFFF_FFFF);
        send_address(32'h8000_7FFF);
        send_address(32'h7FFF_8000);
        set_geometry(4'd12, 4'd9);
        send_address(32'h0012_3456);
        send_address(32'h0012_3FFF);
        set_geometry(4'd13, 4'd8);
        send_address(32'h5555_5555);
        send_address(32'hAAAA_AAAA);
    endtask

    // random traffic, one register setting and idle pattern per phase
    task automatic test_random_traffic();
        int unsigned send_pct[4];
        int unsigned recv_pct[4];
        send_pct = '{0, 84, 0, 9};
        recv_pct = '{0, 0, 84, 9};
        for (int ph = 0; ph < 4; ph++) begin
            int unsigned blk;
            int unsigned sets;
            blk  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(12);
            sets = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(8);
            set_geometry(blk[CFG_W-1:0], sets[CFG_W-1:0]);
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            refill_pool();
            repeat (290) send_address(pick_address());
        end
        // back to the reset geometry for one more burst
        send_idle_pct  = 20;
        recv_stall_pct = 20;
        set_geometry(BLOCK_SIZE_LOG2_RST, SET_COUNT_LOG2_RST);
        refill_pool();
        repeat (60) send_address(pick_address());
    endtask

    // result side holds off for a long stretch while words keep coming
    task automatic test_full_stall();
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        refill_pool();
        hold_request = 300;
        repeat (60) send_address(pick_address());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_addr     <= REG_BLOCK_SIZE_LOG2;
        i_cfg_wr_data  <= '0;
        push           <= 1'b0;
        i_address      <= '0;
        pop            <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        mismatch_count = 0;
        out_of_reset   = 1'b0;
        clear_model();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        out_of_reset = 1'b1;

        test_reset_geometry();
        test_register_extremes();
        test_full_stall();
        test_random_traffic();

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### two_way_lru_cache_lookup.f
hw/rtl/tlc_pkg.sv
hw/rtl/tlc_fifo.sv
hw/rtl/tlc_front.sv
hw/rtl/tlc_back.sv
hw/rtl/two_way_lru_cache_lookup.sv
hw/rtl/tlc_checker.sv
sim/tb_two_way_lru_cache_lookup.sv
